// ===== hdl/sdp_pkg.sv =====
package sdp_pkg;

	localparam int MAX_NONZEROS = 1024;
	localparam int ADDR_W       = $clog2(MAX_NONZEROS);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int KEY_W        = 32;
	localparam int VAL_W        = 32;

	localparam logic FUNC_STORE  = 1'b0;
	localparam logic FUNC_STREAM = 1'b1;

	localparam logic [VAL_W-1:0] FP_ONE  = 32'h3F80_0000;
	localparam logic [VAL_W-1:0] FP_QNAN = 32'h7FC0_0000;

	typedef logic [CNT_W-1:0]  count_t;
	typedef logic signed [11:0] fexp_t;

endpackage

// ===== hdl/sdp_ifs.sv =====
interface sdp_in_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic                      has_element;
	logic [sdp_pkg::KEY_W-1:0] element_key;
	logic [sdp_pkg::VAL_W-1:0] element_value;
	logic                      last_element;

	modport source (output valid, func, has_element, element_key, element_value,
		last_element, input ready);
	modport sink (input valid, func, has_element, element_key, element_value,
		last_element, output ready);
endinterface

interface sdp_out_if;
	logic                      valid;
	logic                      ready;
	logic [sdp_pkg::VAL_W-1:0] result_value;
	logic                      overflow;

	modport source (output valid, result_value, overflow, input ready);
	modport sink (input valid, result_value, overflow, output ready);
endinterface

interface sdp_cfg_if;
	logic valid;
	logic ready;
	logic emit_distance;

	modport source (output valid, emit_distance, input ready);
	modport sink (input valid, emit_distance, output ready);
endinterface

// ===== hdl/sparse_dot_product_merge.sv =====
// channel   dir  payload
// item_in   in   func, has_element, element_key, element_value, last_element
// cfg       in   emit_distance
// result    out  result_value, overflow
//
// First-vector item: one write into the key/value memory, unless it has no element or the store is full.
// Second-vector item: one compare per stored key read, and on a key match the steps
// multiply, normalize, round, add, normalize, round.
// Last item of a second vector: finish and output steps, with add, normalize and round between them in distance mode.
// Reset clears control state only; no memory clearing pass.
// A waiting result stalls the sequencer only when the next result is ready.
module sparse_dot_product_merge (
	input logic        clk,
	input logic        arst_n,
	sdp_in_if.sink     item_in,
	sdp_cfg_if.sink    cfg,
	sdp_out_if.source  result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CMP  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_NRM  = 3'd3;
	localparam logic [2:0] ST_RND  = 3'd4;
	localparam logic [2:0] ST_ADD  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	localparam sdp_pkg::count_t CNT_MAX = sdp_pkg::CNT_W'(sdp_pkg::MAX_NONZEROS);

	logic [2:0]          state_q;
	sdp_pkg::count_t     count_q;
	sdp_pkg::count_t     ptr_q;
	logic                closed_q;
	logic                lost_q;
	logic                emit_q;
	logic                last_q;
	logic                is_add_q;
	logic                dist_q;
	logic [31:0]         acc_q;
	logic [31:0]         key_q;
	logic [31:0]         val_q;
	logic [31:0]         opa_q;
	logic [31:0]         res_q;
	logic [47:0]         x_q;
	sdp_pkg::fexp_t      bexp_q;
	sdp_pkg::fexp_t      efin_q;
	sdp_pkg::fexp_t      sh_q;
	logic                sgn_q;
	logic                spec_q;
	logic [31:0]         specv_q;
	logic                out_v_q;
	logic [31:0]         out_val_q;
	logic                out_ovf_q;

	logic [63:0]         mem [sdp_pkg::MAX_NONZEROS];
	logic [63:0]         rdata_q;
	logic [sdp_pkg::ADDR_W-1:0] rd_addr;

	function automatic logic [5:0] lead48(input logic [47:0] x);
		logic [5:0] l;
		l = '0;
		for (int i = 0; i < 48; i++) begin
			if (x[i])
				l = 6'(i);
		end
		return l;
	endfunction

	function automatic logic [31:0] fp_round(input logic s, input logic [47:0] x,
		input sdp_pkg::fexp_t efin, input sdp_pkg::fexp_t r);
		logic [47:0]    sh;
		logic [47:0]    msk;
		logic           g;
		logic           st;
		logic [24:0]    sig;
		sdp_pkg::fexp_t nr;
		sdp_pkg::fexp_t ef;
		nr  = -r;
		msk = '0;
		if (r <= 12'sd0) begin
			sh = x << nr[5:0];
			g  = 1'b0;
			st = 1'b0;
		end else if (r > 12'sd48) begin
			sh = '0;
			g  = 1'b0;
			st = |x;
		end else begin
			sh  = x >> r[5:0];
			msk = 48'd1 << (r[5:0] - 6'd1);
			g   = |(x & msk);
			st  = |(x & (msk - 48'd1));
		end
		sig = sh[24:0] + 25'(g & (st | sh[0]));
		ef  = efin - 12'sd1 + $signed({10'd0, sig[24:23]});
		if (ef >= 12'sd255)
			return {s, 8'hFF, 23'd0};
		return {s, ef[7:0], sig[22:0]};
	endfunction

	// multiply front end
	logic [7:0]     m_ea, m_eb;
	logic           m_za, m_zb, m_ia, m_ib, m_na, m_nb, m_sign;
	logic [23:0]    m_sa, m_sb;
	logic [47:0]    m_prod;
	sdp_pkg::fexp_t m_bexp;
	logic           m_spec;
	logic [31:0]    m_specv;

	always_comb begin
		m_ea   = opa_q[30:23];
		m_eb   = val_q[30:23];
		m_za   = opa_q[30:0] == '0;
		m_zb   = val_q[30:0] == '0;
		m_ia   = m_ea == 8'hFF && opa_q[22:0] == '0;
		m_ib   = m_eb == 8'hFF && val_q[22:0] == '0;
		m_na   = m_ea == 8'hFF && opa_q[22:0] != '0;
		m_nb   = m_eb == 8'hFF && val_q[22:0] != '0;
		m_sign = opa_q[31] ^ val_q[31];
		m_sa   = {m_ea != '0, opa_q[22:0]};
		m_sb   = {m_eb != '0, val_q[22:0]};
		m_prod = m_sa * m_sb;
		m_bexp = $signed({4'd0, (m_ea == '0) ? 8'd1 : m_ea})
			+ $signed({4'd0, (m_eb == '0) ? 8'd1 : m_eb}) - 12'sd173;
		m_spec  = 1'b1;
		m_specv = {m_sign, 31'd0};
		if (m_na || m_nb || (m_ia && m_zb) || (m_za && m_ib))
			m_specv = sdp_pkg::FP_QNAN;
		else if (m_ia || m_ib)
			m_specv = {m_sign, 8'hFF, 23'd0};
		else if (!(m_za || m_zb))
			m_spec = 1'b0;
	end

	// add front end
	logic [31:0]    a_a, a_b, a_big, a_sml;
	logic           a_ia, a_ib, a_na, a_nb;
	logic [7:0]     a_eb, a_es, a_d;
	logic [26:0]    a_mb, a_ms, a_sm;
	logic [27:0]    a_sum;
	logic           a_spec;
	logic [31:0]    a_specv;

	always_comb begin
		a_a   = dist_q ? sdp_pkg::FP_ONE : opa_q;
		a_b   = dist_q ? {~acc_q[31], acc_q[30:0]} : acc_q;
		a_ia  = a_a[30:23] == 8'hFF && a_a[22:0] == '0;
		a_ib  = a_b[30:23] == 8'hFF && a_b[22:0] == '0;
		a_na  = a_a[30:23] == 8'hFF && a_a[22:0] != '0;
		a_nb  = a_b[30:23] == 8'hFF && a_b[22:0] != '0;
		a_big = (a_b[30:0] > a_a[30:0]) ? a_b : a_a;
		a_sml = (a_b[30:0] > a_a[30:0]) ? a_a : a_b;
		a_eb  = (a_big[30:23] == '0) ? 8'd1 : a_big[30:23];
		a_es  = (a_sml[30:23] == '0) ? 8'd1 : a_sml[30:23];
		a_d   = a_eb - a_es;
		a_mb  = {a_big[30:23] != '0, a_big[22:0], 3'b000};
		a_ms  = {a_sml[30:23] != '0, a_sml[22:0], 3'b000};
		if (a_d >= 8'd27)
			a_sm = {26'd0, |a_ms};
		else
			a_sm = (a_ms >> a_d[4:0])
				| {26'd0, |(a_ms & ((27'd1 << a_d[4:0]) - 27'd1))};
		if (a_big[31] ^ a_sml[31])
			a_sum = {1'b0, a_mb} - {1'b0, a_sm};
		else
			a_sum = {1'b0, a_mb} + {1'b0, a_sm};
		a_spec  = 1'b1;
		a_specv = {a_a[31] & a_b[31], 31'd0};
		if (a_na || a_nb || (a_ia && a_ib && (a_a[31] != a_b[31])))
			a_specv = sdp_pkg::FP_QNAN;
		else if (a_ia)
			a_specv = a_a;
		else if (a_ib)
			a_specv = a_b;
		else if (a_sum != '0)
			a_spec = 1'b0;
	end

	// shared normalize and round
	logic [5:0]     n_lead;
	sdp_pkg::fexp_t n_er, n_efin, n_sh;
	logic [31:0]    rnd;

	always_comb begin
		n_lead = lead48(x_q);
		n_er   = bexp_q + $signed({6'd0, n_lead});
		n_efin = (n_er < 12'sd1) ? 12'sd1 : n_er;
		n_sh   = n_efin - bexp_q - 12'sd23;
		rnd    = spec_q ? specv_q : fp_round(sgn_q, x_q, efin_q, sh_q);
	end

	sdp_pkg::count_t st_cnt;
	sdp_pkg::count_t ptr_nx;
	logic            in_acc;
	logic            st_wr;
	logic            out_load;
	logic [2:0]      after_elem;

	assign st_cnt     = closed_q ? '0 : count_q;
	assign ptr_nx     = ptr_q + sdp_pkg::count_t'(1);
	assign in_acc     = item_in.valid && item_in.ready;
	assign st_wr      = in_acc && item_in.func == sdp_pkg::FUNC_STORE
		&& item_in.has_element && st_cnt < CNT_MAX;
	assign out_load   = state_q == ST_OUT && (!out_v_q || result.ready);
	assign after_elem = last_q ? ST_FIN : ST_IDLE;
	assign rd_addr    = (state_q == ST_CMP) ? ptr_nx[sdp_pkg::ADDR_W-1:0]
		: ptr_q[sdp_pkg::ADDR_W-1:0];

	assign item_in.ready       = state_q == ST_IDLE;
	assign cfg.ready           = 1'b1;
	assign result.valid        = out_v_q;
	assign result.result_value = out_val_q;
	assign result.overflow     = out_ovf_q;

	always_ff @(posedge clk) begin
		if (st_wr)
			mem[st_cnt[sdp_pkg::ADDR_W-1:0]] <= {item_in.element_key, item_in.element_value};
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
		end else if (cfg.valid) begin
			emit_q <= cfg.emit_distance;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q  <= item_in.element_key;
			val_q  <= item_in.element_value;
			last_q <= item_in.last_element;
		end
		unique case (state_q)
			ST_CMP: begin
				if (rdata_q[63:32] == key_q)
					opa_q <= rdata_q[31:0];
			end
			ST_MUL: begin
				x_q     <= m_prod;
				bexp_q  <= m_bexp;
				sgn_q   <= m_sign;
				spec_q  <= m_spec;
				specv_q <= m_specv;
			end
			ST_ADD: begin
				x_q     <= {20'd0, a_sum};
				bexp_q  <= $signed({4'd0, a_eb}) - 12'sd26;
				sgn_q   <= a_big[31];
				spec_q  <= a_spec;
				specv_q <= a_specv;
			end
			ST_NRM: begin
				efin_q <= n_efin;
				sh_q   <= n_sh;
			end
			ST_RND: begin
				if (!is_add_q)
					opa_q <= rnd;
				else if (dist_q)
					res_q <= rnd;
			end
			ST_FIN: begin
				if (!emit_q)
					res_q <= acc_q;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_val_q <= (res_q[30:23] == 8'hFF && res_q[22:0] != '0)
				? sdp_pkg::FP_QNAN : res_q;
			out_ovf_q <= lost_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			ptr_q    <= '0;
			closed_q <= 1'b0;
			lost_q   <= 1'b0;
			is_add_q <= 1'b0;
			dist_q   <= 1'b0;
			acc_q    <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load)
				out_v_q <= 1'b1;
			else if (result.ready)
				out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (item_in.func == sdp_pkg::FUNC_STORE) begin
							if (closed_q || item_in.last_element) begin
								ptr_q <= '0;
								acc_q <= '0;
							end
							closed_q <= item_in.last_element;
							count_q  <= st_wr ? st_cnt + sdp_pkg::count_t'(1) : st_cnt;
							lost_q   <= (closed_q ? 1'b0 : lost_q)
								| (item_in.has_element && st_cnt == CNT_MAX);
						end else begin
							closed_q <= 1'b1;
							if (item_in.has_element && ptr_q < count_q)
								state_q <= ST_CMP;
							else if (item_in.last_element)
								state_q <= ST_FIN;
						end
					end
				end
				ST_CMP: begin
					if (rdata_q[63:32] < key_q) begin
						ptr_q <= ptr_nx;
						if (ptr_nx >= count_q)
							state_q <= after_elem;
					end else if (rdata_q[63:32] == key_q) begin
						ptr_q    <= ptr_nx;
						is_add_q <= 1'b0;
						state_q  <= ST_MUL;
					end else begin
						state_q <= after_elem;
					end
				end
				ST_MUL: begin
					state_q <= ST_NRM;
				end
				ST_ADD: begin
					is_add_q <= 1'b1;
					state_q  <= ST_NRM;
				end
				ST_NRM: begin
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (!is_add_q)
						state_q <= ST_ADD;
					else if (dist_q)
						state_q <= ST_OUT;
					else begin
						acc_q   <= rnd;
						state_q <= after_elem;
					end
				end
				ST_FIN: begin
					if (emit_q) begin
						dist_q  <= 1'b1;
						state_q <= ST_ADD;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						ptr_q   <= '0;
						acc_q   <= '0;
						dist_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= count_q) else $error("walk pointer beyond stored count");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX) else $error("stored count beyond capacity");

	a_lost_full: assert property (@(posedge clk) disable iff (!arst_n)
		lost_q |-> count_q == CNT_MAX) else $error("lost flag with store not full");

	a_cmp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> ptr_q < count_q) else $error("compare on empty entry");

endmodule
